>>> src/stop_and_wait_link_fsm_defines.svh
// assertion macros for the stop-and-wait link engine
`ifndef STOP_AND_WAIT_LINK_FSM_DEFINES_SVH
`define STOP_AND_WAIT_LINK_FSM_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define SAW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define SAW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/saw_pkg.sv
`timescale 1ns / 1ps

package saw_pkg;

   // op codes of an input item
   localparam logic [2:0] OP_RX      = 3'd0;
   localparam logic [2:0] OP_CONNECT = 3'd1;
   localparam logic [2:0] OP_CLOSE   = 3'd2;
   localparam logic [2:0] OP_SEND    = 3'd3;
   localparam logic [2:0] OP_TICK    = 3'd4;

   // received packet types
   localparam logic [15:0] PKT_CON  = 16'd0;
   localparam logic [15:0] PKT_FIN  = 16'd1;
   localparam logic [15:0] PKT_ACK  = 16'd2;
   localparam logic [15:0] PKT_DATA = 16'd3;

   // transmitted packet types
   localparam logic [1:0] TX_CON  = 2'd0;
   localparam logic [1:0] TX_FIN  = 2'd1;
   localparam logic [1:0] TX_ACK  = 2'd2;
   localparam logic [1:0] TX_DATA = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_CONNECT_WAIT = 2'd0;
   localparam logic [1:0] CSR_DATA_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_MAX_RESENDS  = 2'd2;

   localparam logic [7:0] CONNECT_WAIT_RESET = 8'd3;
   localparam logic [7:0] DATA_TIMEOUT_RESET = 8'd3;
   localparam logic [3:0] MAX_RESENDS_RESET  = 4'd3;
   localparam logic [3:0] RESEND_LIMIT       = 4'd15;

   typedef enum logic [1:0] {
      ST_WAIT      = 2'd0,
      ST_CON_SENT  = 2'd1,
      ST_CONNECTED = 2'd2,
      ST_SENDING   = 2'd3
   } state_type;

   typedef enum logic [3:0] {
      EV_CON, EV_FIN, EV_ACK, EV_DATA, EV_CONNECT, EV_CLOSE, EV_SEND, EV_TO, EV_TO_FINAL
   } event_type;

   typedef enum logic [3:0] {
      ACT_NONE, ACT_PASSIVE, ACT_REPCON, ACT_ACTIVE, ACT_CLOSE,
      ACT_SEND, ACT_RESEND, ACT_STOP, ACT_ARM, ACT_DATA
   } action_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] pkt_type;
      logic [63:0] payload;
      logic [8:0]  payload_len;
   } req_type;

   typedef struct packed {
      logic        send_valid;
      logic [1:0]  send_type;
      logic [63:0] send_payload;
      logic [8:0]  send_len;
      logic        deliver_valid;
      logic [63:0] deliver_payload;
      logic [8:0]  deliver_len;
      logic        connected_report;
      logic        closed_report;
      logic [1:0]  link_state;
      logic [3:0]  retry_count;
   } rsp_type;

   // action of the protocol table
   function automatic action_type act_lookup(input state_type s, input event_type e);
      action_type a;
      a = ACT_NONE;
      case (s)
         ST_WAIT: begin
            case (e)
               EV_CON:     a = ACT_PASSIVE;
               EV_CONNECT: a = ACT_ACTIVE;
               default:    a = ACT_NONE;
            endcase
         end
         ST_CON_SENT: begin
            case (e)
               EV_CON:   a = ACT_PASSIVE;
               EV_FIN:   a = ACT_CLOSE;
               EV_ACK:   a = ACT_REPCON;
               EV_CLOSE: a = ACT_CLOSE;
               EV_TO:    a = ACT_CLOSE;
               default:  a = ACT_NONE;
            endcase
         end
         ST_CONNECTED: begin
            case (e)
               EV_FIN:   a = ACT_CLOSE;
               EV_DATA:  a = ACT_DATA;
               EV_CLOSE: a = ACT_CLOSE;
               EV_SEND:  a = ACT_SEND;
               EV_TO:    a = ACT_ARM;
               default:  a = ACT_NONE;
            endcase
         end
         ST_SENDING: begin
            case (e)
               EV_ACK:      a = ACT_STOP;
               EV_DATA:     a = ACT_DATA;
               EV_CLOSE:    a = ACT_CLOSE;
               EV_TO:       a = ACT_RESEND;
               EV_TO_FINAL: a = ACT_CLOSE;
               default:     a = ACT_NONE;
            endcase
         end
         default: a = ACT_NONE;
      endcase
      return a;
   endfunction

   // next state of the protocol table
   function automatic state_type next_lookup(input state_type s, input event_type e);
      state_type n;
      n = s;
      case (s)
         ST_WAIT: begin
            case (e)
               EV_CON:     n = ST_CONNECTED;
               EV_CONNECT: n = ST_CON_SENT;
               default:    n = ST_WAIT;
            endcase
         end
         ST_CON_SENT: begin
            case (e)
               EV_CON:   n = ST_CONNECTED;
               EV_FIN:   n = ST_WAIT;
               EV_ACK:   n = ST_CONNECTED;
               EV_CLOSE: n = ST_WAIT;
               EV_TO:    n = ST_WAIT;
               default:  n = ST_CON_SENT;
            endcase
         end
         ST_CONNECTED: begin
            case (e)
               EV_FIN:   n = ST_WAIT;
               EV_CLOSE: n = ST_WAIT;
               EV_SEND:  n = ST_SENDING;
               EV_TO:    n = ST_SENDING;
               default:  n = ST_CONNECTED;
            endcase
         end
         ST_SENDING: begin
            case (e)
               EV_ACK:      n = ST_CONNECTED;
               EV_DATA:     n = ST_CONNECTED;
               EV_CLOSE:    n = ST_WAIT;
               EV_TO_FINAL: n = ST_WAIT;
               default:     n = ST_SENDING;
            endcase
         end
         default: n = s;
      endcase
      return n;
   endfunction

endpackage

>>> src/stop_and_wait_link_fsm.sv
`timescale 1ns / 1ps
// Stop-and-wait link engine: connection set-up, acknowledged data transfer,
// resend on timeout and suppression of duplicate received data.
// req_ channel: one event item per handshake (received packet, connect,
// close, send request or timer tick). rsp_ channel: exactly one result item
// per event item: the packet to transmit, delivered data, connect and close
// reports, the link state and the resend count after the event.
// csr_ port: plain write of the connect wait (0), data_timeout (1) and
// max_resends (2); other indexes are ignored. Write only while idle.
// An accepted item sits in the input register, and its result is loaded into
// the output register once that register is free (empty or its item taken).
// Throughput: one item per cycle while the receiver does not stall; the
// protocol table, timer update and 64-bit duplicate compare all resolve
// between the input and output registers.
// Receiver stall: the result holds in the output register; one more item is
// still taken into the input register, then req_stall rises until the result
// is taken.
// Reset: waiting state, timer stopped, resend count and saved data cleared,
// registers back to 3 / 3 / 3, both channels empty.
module stop_and_wait_link_fsm #(
   parameter int PAYLOAD_BITS = 64,
   parameter int MAX_LEN      = 500,
   parameter int TIMER_BITS   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  saw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output saw_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_addr,
   input  logic [7:0]       csr_wdata
);

   // load path width: wide enough for both the register and the timer
   localparam int LoadW = (TIMER_BITS > 8) ? TIMER_BITS : 8;
   localparam logic [LoadW-1:0] TimerMax = LoadW'((64'd1 << TIMER_BITS) - 64'd1);
   localparam logic [63:0] PayMask = 64'(~64'd0 >> (64 - PAYLOAD_BITS));
   localparam logic [8:0] MaxLen = 9'(MAX_LEN);

   // timeout register value saturated into the timer range
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [7:0] v);
      logic [LoadW-1:0] ext;
      ext = LoadW'(v);
      if (ext > TimerMax) begin
         ext = TimerMax;
      end
      return TIMER_BITS'(ext);
   endfunction

   // configuration registers
   logic [7:0] connect_wait_ff;
   logic [7:0] data_timeout_ff;
   logic [3:0] max_resends_ff;

   // pipeline registers
   logic             in_valid_ff, in_valid_in;
   saw_pkg::req_type in_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   saw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // protocol state
   saw_pkg::state_type    state_ff, state_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [3:0]            resend_ff, resend_in;
   logic [63:0]           saved_pay_ff, saved_pay_in;
   logic [8:0]            saved_len_ff, saved_len_in;
   logic [63:0]           last_pay_ff, last_pay_in;
   logic [8:0]            last_len_ff, last_len_in;

   // decode of the item held in the input register
   logic                  ev_valid;
   saw_pkg::event_type    ev;
   saw_pkg::action_type   act;
   logic [TIMER_BITS-1:0] timer_dec;
   logic [3:0]            resend_dec;
   logic [63:0]           pay;
   logic [8:0]            len;

   logic out_adv;
   logic in_load;
   logic fire;

   // the output register frees when empty or when its item is taken
   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_adv;
   assign in_load   = req_valid && !req_stall;
   assign fire      = in_valid_ff && out_adv;

   assign in_valid_in  = in_load ? 1'b1 : (out_adv ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = out_adv ? in_valid_ff : rsp_valid_ff;

   assign pay = in_item_ff.payload & PayMask;
   assign len = (in_item_ff.payload_len > MaxLen) ? MaxLen : in_item_ff.payload_len;

   // event decode, including the tick countdown and expiry
   always_comb begin
      ev_valid   = 1'b0;
      ev         = saw_pkg::EV_CON;
      timer_dec  = timer_ff;
      resend_dec = resend_ff;
      case (in_item_ff.op)
         saw_pkg::OP_RX: begin
            ev_valid = 1'b1;
            case (in_item_ff.pkt_type)
               saw_pkg::PKT_CON:  ev = saw_pkg::EV_CON;
               saw_pkg::PKT_FIN:  ev = saw_pkg::EV_FIN;
               saw_pkg::PKT_ACK:  ev = saw_pkg::EV_ACK;
               saw_pkg::PKT_DATA: ev = saw_pkg::EV_DATA;
               default:           ev_valid = 1'b0;
            endcase
         end
         saw_pkg::OP_CONNECT: begin
            ev_valid = 1'b1;
            ev       = saw_pkg::EV_CONNECT;
         end
         saw_pkg::OP_CLOSE: begin
            ev_valid = 1'b1;
            ev       = saw_pkg::EV_CLOSE;
         end
         saw_pkg::OP_SEND: begin
            ev_valid = 1'b1;
            ev       = saw_pkg::EV_SEND;
         end
         saw_pkg::OP_TICK: begin
            // a stopped timer ignores the tick
            if (timer_ff != '0) begin
               timer_dec = timer_ff - 1'b1;
               if (timer_dec == '0) begin
                  ev_valid = 1'b1;
                  if (resend_ff < max_resends_ff) begin
                     ev = saw_pkg::EV_TO;
                  end else begin
                     // final timeout clears the resend count in any state
                     ev         = saw_pkg::EV_TO_FINAL;
                     resend_dec = '0;
                  end
               end
            end
         end
         default: ev_valid = 1'b0;
      endcase
   end

   assign act = ev_valid ? saw_pkg::act_lookup(state_ff, ev) : saw_pkg::ACT_NONE;

   // next state
   always_comb begin
      state_in = state_ff;
      if (ev_valid) begin
         state_in = saw_pkg::next_lookup(state_ff, ev);
      end
   end

   // actions and result fields
   always_comb begin
      timer_in     = timer_dec;
      resend_in    = resend_dec;
      saved_pay_in = saved_pay_ff;
      saved_len_in = saved_len_ff;
      last_pay_in  = last_pay_ff;
      last_len_in  = last_len_ff;
      rsp_data_in  = '0;
      case (act)
         saw_pkg::ACT_PASSIVE: begin
            rsp_data_in.send_valid       = 1'b1;
            rsp_data_in.send_type        = saw_pkg::TX_ACK;
            rsp_data_in.connected_report = 1'b1;
            timer_in                     = '0;
         end
         saw_pkg::ACT_REPCON: begin
            rsp_data_in.connected_report = 1'b1;
            timer_in                     = '0;
         end
         saw_pkg::ACT_ACTIVE: begin
            rsp_data_in.send_valid = 1'b1;
            rsp_data_in.send_type  = saw_pkg::TX_CON;
            timer_in               = timer_load(connect_wait_ff);
         end
         saw_pkg::ACT_CLOSE: begin
            rsp_data_in.send_valid    = 1'b1;
            rsp_data_in.send_type     = saw_pkg::TX_FIN;
            rsp_data_in.closed_report = 1'b1;
         end
         saw_pkg::ACT_SEND: begin
            rsp_data_in.send_valid   = 1'b1;
            rsp_data_in.send_type    = saw_pkg::TX_DATA;
            rsp_data_in.send_payload = pay;
            rsp_data_in.send_len     = len;
            saved_pay_in             = pay;
            saved_len_in             = len;
            timer_in                 = timer_load(data_timeout_ff);
         end
         saw_pkg::ACT_RESEND: begin
            if (resend_ff < saw_pkg::RESEND_LIMIT) begin
               resend_in = resend_ff + 1'b1;
            end
            rsp_data_in.send_valid   = 1'b1;
            rsp_data_in.send_type    = saw_pkg::TX_DATA;
            rsp_data_in.send_payload = saved_pay_ff;
            rsp_data_in.send_len     = saved_len_ff;
            timer_in                 = timer_load(data_timeout_ff);
         end
         saw_pkg::ACT_STOP: begin
            timer_in  = '0;
            resend_in = '0;
         end
         saw_pkg::ACT_ARM: begin
            timer_in = timer_load(data_timeout_ff);
         end
         saw_pkg::ACT_DATA: begin
            // always acknowledged, delivered only when it differs from the last
            rsp_data_in.send_valid = 1'b1;
            rsp_data_in.send_type  = saw_pkg::TX_ACK;
            if (pay != last_pay_ff || len != last_len_ff) begin
               rsp_data_in.deliver_valid   = 1'b1;
               rsp_data_in.deliver_payload = pay;
               rsp_data_in.deliver_len     = len;
               last_pay_in                 = pay;
               last_len_in                 = len;
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.link_state  = state_in;
      rsp_data_in.retry_count = resend_in;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         connect_wait_ff <= saw_pkg::CONNECT_WAIT_RESET;
         data_timeout_ff <= saw_pkg::DATA_TIMEOUT_RESET;
         max_resends_ff  <= saw_pkg::MAX_RESENDS_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            saw_pkg::CSR_CONNECT_WAIT: connect_wait_ff <= csr_wdata;
            saw_pkg::CSR_DATA_TIMEOUT: data_timeout_ff <= csr_wdata;
            saw_pkg::CSR_MAX_RESENDS:  max_resends_ff  <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // handshake control and protocol state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= saw_pkg::ST_WAIT;
         timer_ff     <= '0;
         resend_ff    <= '0;
         saved_pay_ff <= '0;
         saved_len_ff <= '0;
         last_pay_ff  <= '0;
         last_len_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff     <= state_in;
            timer_ff     <= timer_in;
            resend_ff    <= resend_in;
            saved_pay_ff <= saved_pay_in;
            saved_len_ff <= saved_len_in;
            last_pay_ff  <= last_pay_in;
            last_len_ff  <= last_len_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_item_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/saw_checker.sv
`timescale 1ns / 1ps
`include "stop_and_wait_link_fsm_defines.svh"

module saw_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input saw_pkg::rsp_type rsp_data
);

   logic rsp_wait;
   logic send_off;
   logic send_clear;
   logic got_deliver;
   logic deliver_ack;
   logic got_close;
   logic close_fin;
   logic got_connect;
   logic connect_ok;

   assign rsp_wait    = rsp_valid && rsp_stall;
   assign send_off    = rsp_valid && !rsp_data.send_valid;
   assign send_clear  = rsp_data.send_payload == 64'd0 && rsp_data.send_len == 9'd0;
   assign got_deliver = rsp_valid && rsp_data.deliver_valid;
   assign deliver_ack = rsp_data.send_valid && rsp_data.send_type == saw_pkg::TX_ACK &&
                        rsp_data.link_state == saw_pkg::ST_CONNECTED;
   assign got_close   = rsp_valid && rsp_data.closed_report;
   assign close_fin   = rsp_data.send_valid && rsp_data.send_type == saw_pkg::TX_FIN &&
                        rsp_data.link_state == saw_pkg::ST_WAIT;
   assign got_connect = rsp_valid && rsp_data.connected_report;
   assign connect_ok  = rsp_data.link_state == saw_pkg::ST_CONNECTED &&
                        !rsp_data.closed_report;

   // a stalled result holds
   `SAW_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_data), "result changed under stall")

   // no packet means no packet data
   `SAW_ASSERT_NOW(a_send_zero, send_off, send_clear, "send fields set without a packet")

   // delivered data is always acknowledged and leaves the link connected
   `SAW_ASSERT_NOW(a_deliver_ack, got_deliver, deliver_ack, "delivery without ack")

   // a close report sends FIN and returns to waiting
   `SAW_ASSERT_NOW(a_close_fin, got_close, close_fin, "close without fin")

   // a connect report lands in the connected state
   `SAW_ASSERT_NOW(a_connect_state, got_connect, connect_ok, "connect report in wrong state")

endmodule

bind stop_and_wait_link_fsm saw_checker u_saw_checker (.*);

>>> tb/sv/stop_and_wait_link_fsm_tb.sv
`timescale 1ns / 1ps

module stop_and_wait_link_fsm_tb;

   localparam int LIMIT_CYCLES = 400000;
   localparam int TICK_CAP     = 300;
   localparam int LONG_HOLD    = 80;

   // op codes the block must ignore
   localparam logic [2:0] OP_BAD_FIRST = 3'd5;
   localparam logic [2:0] OP_BAD_LAST  = 3'd7;
   // register index with no register behind it
   localparam logic [1:0] CSR_SPARE    = 2'd3;

   // tracks the link engine state and holds the expected result items
   class link_tracker;
      logic [7:0]         conn_to;
      logic [7:0]         data_to;
      logic [3:0]         max_res;
      saw_pkg::state_type link;
      logic [7:0]         timer;
      logic [3:0]         resends;
      logic [63:0]        saved_pay;
      logic [8:0]         saved_len;
      logic [63:0]        last_pay;
      logic [8:0]         last_len;
      saw_pkg::rsp_type   expected_rsp[$];
      int                 errors;
      int                 items;
      int                 checked;
      int                 deliveries;
      int                 resend_cnt;
      int                 closes;
      int                 final_tos;

      function new();
         conn_to    = saw_pkg::CONNECT_WAIT_RESET;
         data_to    = saw_pkg::DATA_TIMEOUT_RESET;
         max_res    = saw_pkg::MAX_RESENDS_RESET;
         link       = saw_pkg::ST_WAIT;
         timer      = '0;
         resends    = '0;
         saved_pay  = '0;
         saved_len  = '0;
         last_pay   = '0;
         last_len   = '0;
         errors     = 0;
         items      = 0;
         checked    = 0;
         deliveries = 0;
         resend_cnt = 0;
         closes     = 0;
         final_tos  = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] val);
         case (idx)
            saw_pkg::CSR_CONNECT_WAIT: conn_to = val;
            saw_pkg::CSR_DATA_TIMEOUT: data_to = val;
            saw_pkg::CSR_MAX_RESENDS:  max_res = val[3:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function void note_item(saw_pkg::req_type it);
         saw_pkg::rsp_type   r;
         saw_pkg::event_type ev;
         bit                 fires;
         bit                 do_fin;
         logic [8:0]         len;
         r      = '0;
         ev     = saw_pkg::EV_CON;
         fires  = 1'b0;
         do_fin = 1'b0;
         len    = (it.payload_len > 9'd500) ? 9'd500 : it.payload_len;
         items++;
         // turn the item into a protocol event, if any
         case (it.op)
            saw_pkg::OP_RX: begin
               fires = 1'b1;
               case (it.pkt_type)
                  saw_pkg::PKT_CON:  ev = saw_pkg::EV_CON;
                  saw_pkg::PKT_FIN:  ev = saw_pkg::EV_FIN;
                  saw_pkg::PKT_ACK:  ev = saw_pkg::EV_ACK;
                  saw_pkg::PKT_DATA: ev = saw_pkg::EV_DATA;
                  default:           fires = 1'b0;
               endcase
            end
            saw_pkg::OP_CONNECT: begin fires = 1'b1; ev = saw_pkg::EV_CONNECT; end
            saw_pkg::OP_CLOSE:   begin fires = 1'b1; ev = saw_pkg::EV_CLOSE; end
            saw_pkg::OP_SEND:    begin fires = 1'b1; ev = saw_pkg::EV_SEND; end
            saw_pkg::OP_TICK: begin
               if (timer != 8'd0) begin
                  timer = timer - 8'd1;
                  if (timer == 8'd0) begin
                     fires = 1'b1;
                     if (resends < max_res) begin
                        ev = saw_pkg::EV_TO;
                     end else begin
                        resends = '0;
                        ev = saw_pkg::EV_TO_FINAL;
                        final_tos++;
                     end
                  end
               end
            end
            default: ;
         endcase
         if (fires) begin
            case (ev)
               saw_pkg::EV_CON: begin
                  if (link == saw_pkg::ST_WAIT || link == saw_pkg::ST_CON_SENT) begin
                     r.send_valid       = 1'b1;
                     r.send_type        = saw_pkg::TX_ACK;
                     r.connected_report = 1'b1;
                     timer = '0;
                     link  = saw_pkg::ST_CONNECTED;
                  end
               end
               saw_pkg::EV_FIN:
                  do_fin = (link == saw_pkg::ST_CON_SENT || link == saw_pkg::ST_CONNECTED);
               saw_pkg::EV_ACK: begin
                  if (link == saw_pkg::ST_CON_SENT) begin
                     r.connected_report = 1'b1;
                     timer = '0;
                     link  = saw_pkg::ST_CONNECTED;
                  end else if (link == saw_pkg::ST_SENDING) begin
                     timer   = '0;
                     resends = '0;
                     link    = saw_pkg::ST_CONNECTED;
                  end
               end
               saw_pkg::EV_DATA: begin
                  if (link == saw_pkg::ST_CONNECTED || link == saw_pkg::ST_SENDING) begin
                     r.send_valid = 1'b1;
                     r.send_type  = saw_pkg::TX_ACK;
                     // duplicates are acked but not delivered
                     if (it.payload != last_pay || len != last_len) begin
                        r.deliver_valid   = 1'b1;
                        r.deliver_payload = it.payload;
                        r.deliver_len     = len;
                        last_pay = it.payload;
                        last_len = len;
                        deliveries++;
                     end
                     link = saw_pkg::ST_CONNECTED;
                  end
               end
               saw_pkg::EV_CONNECT: begin
                  if (link == saw_pkg::ST_WAIT) begin
                     r.send_valid = 1'b1;
                     r.send_type  = saw_pkg::TX_CON;
                     timer = conn_to;
                     link  = saw_pkg::ST_CON_SENT;
                  end
               end
               saw_pkg::EV_CLOSE: do_fin = (link != saw_pkg::ST_WAIT);
               saw_pkg::EV_SEND: begin
                  if (link == saw_pkg::ST_CONNECTED) begin
                     r.send_valid   = 1'b1;
                     r.send_type    = saw_pkg::TX_DATA;
                     r.send_payload = it.payload;
                     r.send_len     = len;
                     saved_pay = it.payload;
                     saved_len = len;
                     timer = data_to;
                     link  = saw_pkg::ST_SENDING;
                  end
               end
               saw_pkg::EV_TO: begin
                  case (link)
                     saw_pkg::ST_CON_SENT: do_fin = 1'b1;
                     saw_pkg::ST_CONNECTED: begin
                        // late expiry after data arrived while sending
                        timer = data_to;
                        link  = saw_pkg::ST_SENDING;
                     end
                     saw_pkg::ST_SENDING: begin
                        if (resends != saw_pkg::RESEND_LIMIT) resends = resends + 4'd1;
                        r.send_valid   = 1'b1;
                        r.send_type    = saw_pkg::TX_DATA;
                        r.send_payload = saved_pay;
                        r.send_len     = saved_len;
                        timer = data_to;
                        resend_cnt++;
                     end
                     default: ;
                  endcase
               end
               saw_pkg::EV_TO_FINAL: do_fin = (link == saw_pkg::ST_SENDING);
               default: ;
            endcase
            // every close sends FIN and goes back to waiting, timer untouched
            if (do_fin) begin
               r.send_valid    = 1'b1;
               r.send_type     = saw_pkg::TX_FIN;
               r.closed_report = 1'b1;
               link = saw_pkg::ST_WAIT;
               closes++;
            end
         end
         r.link_state  = link;
         r.retry_count = resends;
         expected_rsp.push_back(r);
      endfunction

      function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_rsp(saw_pkg::rsp_type got);
         saw_pkg::rsp_type want;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item, expected none, actual %h", $time, got);
         end else begin
            want = expected_rsp.pop_front();
            checked++;
            cmp_field("send_valid", want.send_valid, got.send_valid);
            cmp_field("send_type", want.send_type, got.send_type);
            cmp_field("send_payload", want.send_payload, got.send_payload);
            cmp_field("send_len", want.send_len, got.send_len);
            cmp_field("deliver_valid", want.deliver_valid, got.deliver_valid);
            cmp_field("deliver_payload", want.deliver_payload, got.deliver_payload);
            cmp_field("deliver_len", want.deliver_len, got.deliver_len);
            cmp_field("connected_report", want.connected_report, got.connected_report);
            cmp_field("closed_report", want.closed_report, got.closed_report);
            cmp_field("link_state", want.link_state, got.link_state);
            cmp_field("retry_count", want.retry_count, got.retry_count);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   saw_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   saw_pkg::rsp_type rsp_data;
   logic             csr_wr_en;
   logic [1:0]       csr_addr;
   logic [7:0]       csr_wdata;

   link_tracker sb;
   int          cycle_count   = 0;
   int          burst_left    = 0;
   int          stim_count    = 0;
   int          hold_requests = 0;
   int          hold_served   = 0;
   int          hold_left     = 0;
   int          stall_mode    = 0;
   int          seg_left      = 0;
   logic [63:0] gen_pay       = '0;
   logic [8:0]  gen_len       = '0;

   stop_and_wait_link_fsm dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // both channels are observed at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_item(req_data);
         if (rsp_valid && !rsp_stall) sb.check_rsp(rsp_data);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stall segments, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if (seg_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            seg_left   = $urandom_range(20, 150);
         end
         seg_left--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ((seg_left % 8) < 3);
         endcase
      end
   end

   function automatic logic [63:0] rand_pay();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly legal lengths, some above the 500 byte cap
   function automatic logic [8:0] rand_len();
      case ($urandom_range(0, 7))
         0:       return 9'd0;
         1:       return 9'($urandom_range(500, 511));
         default: return 9'($urandom_range(1, 500));
      endcase
   endfunction

   function automatic saw_pkg::req_type mk(logic [2:0] op, logic [15:0] pt,
                                           logic [63:0] pay, logic [8:0] len);
      saw_pkg::req_type it;
      it.op          = op;
      it.pkt_type    = pt;
      it.payload     = pay;
      it.payload_len = len;
      return it;
   endfunction

   // local request or tick, the unused fields carry random bits
   function automatic saw_pkg::req_type mk_op(logic [2:0] op);
      return mk(op, 16'($urandom), rand_pay(), rand_len());
   endfunction

   function automatic saw_pkg::req_type rx_ctl(logic [15:0] pt);
      return mk(saw_pkg::OP_RX, pt, rand_pay(), rand_len());
   endfunction

   function automatic saw_pkg::req_type noise_item();
      logic [15:0] pt;
      pt = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      return mk(3'($urandom_range(0, 7)), pt, rand_pay(), rand_len());
   endfunction

   // sender: bursts of items with random gaps in between
   task automatic push(input saw_pkg::req_type it, input bit counted);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      if (counted) stim_count++;
   endtask

   task automatic tick_run(input int n);
      if (n > TICK_CAP) n = TICK_CAP;
      repeat (n) push(mk_op(saw_pkg::OP_TICK), 1'b1);
   endtask

   // received data: new, same word, same length or an exact repeat
   task automatic rx_data(input int kind);
      logic [63:0] w;
      logic [8:0]  l;
      case (kind)
         0:       begin w = rand_pay(); l = rand_len(); end
         1:       begin w = gen_pay;    l = rand_len(); end
         2:       begin w = rand_pay(); l = gen_len;    end
         default: begin w = gen_pay;    l = gen_len;    end
      endcase
      gen_pay = w;
      gen_len = l;
      push(mk(saw_pkg::OP_RX, saw_pkg::PKT_DATA, w, l), 1'b1);
   endtask

   // one connection: open, a few exchanges, maybe a close
   task automatic run_session();
      int conn;
      int dt;
      int mr;
      conn = sb.conn_to;
      dt   = sb.data_to;
      mr   = sb.max_res;
      // bring the link back to waiting first
      if ($urandom_range(0, 3) == 0) push(rx_ctl(saw_pkg::PKT_FIN), 1'b1);
      else push(mk_op(saw_pkg::OP_CLOSE), 1'b1);
      case ($urandom_range(0, 3))
         0: begin
            push(mk_op(saw_pkg::OP_CONNECT), 1'b1);
            tick_run(conn > 0 ? $urandom_range(0, conn - 1) : $urandom_range(0, 3));
            push(rx_ctl(saw_pkg::PKT_ACK), 1'b1);
         end
         1: begin
            // connect timeout closes, then the peer opens
            push(mk_op(saw_pkg::OP_CONNECT), 1'b1);
            tick_run(conn > 0 ? conn : 2);
            push(rx_ctl(saw_pkg::PKT_CON), 1'b1);
         end
         2: begin
            push(mk_op(saw_pkg::OP_CONNECT), 1'b1);
            push(rx_ctl(saw_pkg::PKT_CON), 1'b1);
         end
         default: push(rx_ctl(saw_pkg::PKT_CON), 1'b1);
      endcase
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 7))
            0, 1, 2: begin
               push(mk_op(saw_pkg::OP_SEND), 1'b1);
               case ($urandom_range(0, 3))
                  0: push(rx_ctl(saw_pkg::PKT_ACK), 1'b1);
                  1: begin
                     tick_run(dt * $urandom_range(1, mr + 1));
                     push(rx_ctl(saw_pkg::PKT_ACK), 1'b1);
                  end
                  2: begin
                     tick_run($urandom_range(0, dt));
                     rx_data(0);
                  end
                  default: begin
                     // resends run out, then the peer reopens
                     tick_run(dt * (mr + 1));
                     push(rx_ctl(saw_pkg::PKT_CON), 1'b1);
                  end
               endcase
            end
            3, 4:    rx_data($urandom_range(0, 2));
            5:       rx_data(3);
            6:       tick_run($urandom_range(1, dt + 1));
            default: repeat ($urandom_range(1, 3)) push(noise_item(), 1'b0);
         endcase
      end
      case ($urandom_range(0, 2))
         0:       push(mk_op(saw_pkg::OP_CLOSE), 1'b1);
         1:       push(rx_ctl(saw_pkg::PKT_FIN), 1'b1);
         default: ;
      endcase
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // drain the block, then load a new register setting
   task automatic configure(input logic [7:0] conn, input logic [7:0] dt,
                            input logic [7:0] mr);
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write(saw_pkg::CSR_CONNECT_WAIT, conn);
      csr_write(saw_pkg::CSR_DATA_TIMEOUT, dt);
      csr_write(saw_pkg::CSR_MAX_RESENDS, mr);
   endtask

   task automatic fill(input int target);
      int start;
      start = stim_count;
      while (stim_count - start < target) run_session();
   endtask

   initial begin
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_addr  = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass with the reset register values
      push(mk(saw_pkg::OP_TICK, 16'h0000, '0, 9'd0), 1'b1);
      push(mk(OP_BAD_LAST, 16'hFFFF, '1, 9'h1FF), 1'b1);
      push(mk(OP_BAD_FIRST, 16'hFFFF, '1, 9'h1FF), 1'b1);
      push(mk(saw_pkg::OP_RX, 16'hFFFF, '1, 9'd0), 1'b1);
      push(mk(saw_pkg::OP_RX, saw_pkg::PKT_DATA + 16'd1, '0, 9'd7), 1'b1);
      push(rx_ctl(saw_pkg::PKT_FIN), 1'b1);
      push(mk_op(saw_pkg::OP_CONNECT), 1'b1);
      tick_run(2);
      push(rx_ctl(saw_pkg::PKT_ACK), 1'b1);
      // zero word and zero length match the empty receive history
      push(mk(saw_pkg::OP_RX, saw_pkg::PKT_DATA, '0, 9'd0), 1'b1);
      push(mk(saw_pkg::OP_RX, saw_pkg::PKT_DATA, '1, 9'h1FF), 1'b1);
      push(mk(saw_pkg::OP_RX, saw_pkg::PKT_DATA, '1, 9'd500), 1'b1);
      push(mk(saw_pkg::OP_SEND, saw_pkg::PKT_CON, 64'hA5A5_5A5A_F00F_0FF0, 9'd501), 1'b1);
      tick_run(3);
      push(mk(saw_pkg::OP_RX, saw_pkg::PKT_DATA, 64'h0123_4567_89AB_CDEF, 9'd1), 1'b1);
      tick_run(3);
      push(rx_ctl(saw_pkg::PKT_ACK), 1'b1);
      push(mk_op(saw_pkg::OP_CLOSE), 1'b1);
      push(rx_ctl(saw_pkg::PKT_CON), 1'b1);
      push(rx_ctl(saw_pkg::PKT_FIN), 1'b1);
      gen_pay = 64'h0123_4567_89AB_CDEF;
      gen_len = 9'd1;

      // connect timer off, one-tick data timer, no resends
      configure(8'd0, 8'd1, 8'd0);
      csr_write(CSR_SPARE, 8'hFF);
      push(mk_op(saw_pkg::OP_CONNECT), 1'b1);
      push(mk_op(saw_pkg::OP_TICK), 1'b1);
      push(rx_ctl(saw_pkg::PKT_CON), 1'b1);
      push(mk_op(saw_pkg::OP_SEND), 1'b1);
      push(mk_op(saw_pkg::OP_TICK), 1'b1);
      push(rx_ctl(saw_pkg::PKT_ACK), 1'b1);
      fill(300);

      // largest timers and resend limit
      configure(8'hFF, 8'hFF, 8'hFF);
      fill(300);

      // small random timers, long receiver hold-off partway through
      configure(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)), 8'($urandom));
      fill(100);
      hold_requests++;
      fill(350);

      // data timer off, send stays pending until acked
      configure(8'd1, 8'd0, 8'd15);
      fill(300);

      configure(8'($urandom_range(1, 5)), 8'($urandom_range(1, 4)),
                8'($urandom_range(0, 4)));
      fill(450);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("%0d event items sent, %0d results checked over six register settings",
               sb.items, sb.checked);
      $display("%0d deliveries, %0d resends, %0d closes, %0d final timeouts",
               sb.deliveries, sb.resend_cnt, sb.closes, sb.final_tos);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
